[rtl/lzwvwd_pkg.sv]
`timescale 1ns / 1ps

package lzwvwd_pkg;

  localparam int DICT_BITS_DEF = 12;
  localparam int LEN_W         = 16;
  localparam int LIT_COUNT     = 256;
  localparam int CW_START      = 9;
  localparam int LIMIT_START   = 511;

  typedef enum logic [1:0] {
    OP_FEED    = 2'd0,
    OP_PULL    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_RUN     = 2'd0,
    STAT_CORRUPT = 2'd1,
    STAT_DONE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CODE,
    S_WALK,
    S_LIT,
    S_UPD,
    S_POP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] stream_byte;
  } cmd_t;

  typedef struct packed {
    logic       accepted;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       last_byte;
    logic [1:0] status;
  } rsp_t;

endpackage

[rtl/lzwvwd_if.sv]
`timescale 1ns / 1ps

interface lzwvwd_cmd_if;
  logic               valid;
  logic               ready;
  lzwvwd_pkg::cmd_t   item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface lzwvwd_rsp_if;
  logic               valid;
  logic               ready;
  lzwvwd_pkg::rsp_t   item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[rtl/lzwvwd_ram.sv]
`timescale 1ns / 1ps

module lzwvwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lzw_variable_width_decoder.sv]
`timescale 1ns / 1ps
// Path, accept to result register loaded: no-op, restart, refused feed or feed without a
// full code go straight to the output state; pull makes one stack memory read in the pop
// state; a feed with a corrupt code passes the code state only. A feed completing a valid
// code runs the code state, a chain walk with one dictionary memory read per entry chased,
// then the literal and update states. The output state waits for a free response slot.
// Flow: one transaction at a time; input is ready only while idle. Reset: synchronous,
// active high; clears all control state, no memory clearing pass.
module lzw_variable_width_decoder #(
  parameter int DICT_BITS = lzwvwd_pkg::DICT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           length_we,
  input  logic [lzwvwd_pkg::LEN_W-1:0]   length_data,
  lzwvwd_cmd_if.sink                     cmd,
  lzwvwd_rsp_if.source                   rsp
);

  localparam int DICT_SIZE   = 1 << DICT_BITS;
  localparam int RESET_INDEX = DICT_SIZE - 2;
  localparam int SP_W        = DICT_BITS + 1;
  localparam int ACC_W       = DICT_BITS + 8;
  localparam int ENT_W       = DICT_BITS + 8;
  localparam int LEN_W       = lzwvwd_pkg::LEN_W;

  localparam logic [DICT_BITS-1:0] LIT_LIMIT = DICT_BITS'(lzwvwd_pkg::LIT_COUNT);
  localparam logic [DICT_BITS-1:0] RST_IDX   = DICT_BITS'(RESET_INDEX);
  localparam logic [DICT_BITS-1:0] LIM_START = DICT_BITS'(lzwvwd_pkg::LIMIT_START);
  localparam logic [4:0]           CW_START  = 5'(lzwvwd_pkg::CW_START);
  localparam logic [4:0]           CW_MAX    = 5'(DICT_BITS);

  lzwvwd_pkg::state_t state, state_next;

  // decoder state
  logic [LEN_W-1:0]     out_len;
  logic [ACC_W-1:0]     acc;
  logic [4:0]           held;
  logic [DICT_BITS-1:0] prev_code;
  logic [DICT_BITS-1:0] next_index;
  logic [4:0]           code_width;
  logic [DICT_BITS-1:0] width_limit;
  logic [7:0]           first_char;
  logic                 fresh;
  logic [LEN_W-1:0]     bytes_written;
  logic                 corrupt;
  // stack: entries [base, sp) are live, popped from the top
  logic [SP_W-1:0]      sp;
  logic [SP_W-1:0]      base;
  // per-transaction work registers
  logic [DICT_BITS-1:0] code;
  logic [DICT_BITS-1:0] cur;
  logic                 was_fresh;
  logic                 res_accepted;
  logic                 res_valid;
  logic [7:0]           res_byte;
  logic                 res_last;
  logic                 out_v;
  lzwvwd_pkg::rsp_t     out_item;

  // memory ports
  logic                 dict_we, dict_re;
  logic [DICT_BITS-1:0] dict_waddr, dict_raddr;
  logic [ENT_W-1:0]     dict_wdata, dict_rdata;
  logic                 stk_we, stk_re;
  logic [DICT_BITS-1:0] stk_raddr;
  logic [7:0]           stk_wdata, stk_rdata;

  lzwvwd_ram #(.WIDTH(ENT_W), .DEPTH(DICT_SIZE)) u_dict (
    .clk  (clk),
    .we   (dict_we),
    .waddr(dict_waddr),
    .wdata(dict_wdata),
    .re   (dict_re),
    .raddr(dict_raddr),
    .rdata(dict_rdata)
  );

  lzwvwd_ram #(.WIDTH(8), .DEPTH(DICT_SIZE)) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(sp[DICT_BITS-1:0]),
    .wdata(stk_wdata),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  // Unpack: append the fed byte, then cut one code from the top if enough bits are held.
  logic [ACC_W-1:0]     acc_ext, acc_shift, acc_keep;
  logic [4:0]           held_ext, shamt;
  logic                 have_code;
  logic [DICT_BITS-1:0] code_new, cw_mask;

  always_comb begin
    acc_ext   = {acc[ACC_W-9:0], cmd.item.stream_byte};
    held_ext  = held + 5'd8;
    have_code = held_ext >= code_width;
    shamt     = held_ext - code_width;
    acc_shift = acc_ext >> shamt;
    cw_mask   = ~({DICT_BITS{1'b1}} << code_width);
    code_new  = acc_shift[DICT_BITS-1:0] & cw_mask;
    acc_keep  = acc_ext & ~({ACC_W{1'b1}} << shamt);
  end

  logic                 cmd_acc;
  logic                 stack_empty;
  logic                 done;
  logic                 slot_free;
  logic                 corrupt_hit;
  logic [DICT_BITS-1:0] walk_next;
  logic [LEN_W-1:0]     remaining;
  logic                 trunc;
  logic [SP_W-1:0]      keep;

  assign cmd_acc     = cmd.valid & cmd.ready;
  assign stack_empty = (sp == base);
  assign done        = (bytes_written >= out_len);
  assign slot_free   = !out_v || rsp.ready;
  assign corrupt_hit = fresh ? (code >= LIT_LIMIT) : (code > next_index);
  assign walk_next   = dict_rdata[ENT_W-1:8];
  assign remaining   = out_len - bytes_written;
  assign trunc       = (LEN_W + 1)'(sp) > (LEN_W + 1)'(remaining);
  assign keep        = trunc ? SP_W'(remaining) : sp;

  // Next state and memory controls
  always_comb begin
    state_next = state;
    cmd.ready  = (state == lzwvwd_pkg::S_IDLE);
    dict_we    = 1'b0;
    dict_waddr = next_index;
    dict_wdata = {prev_code, cur[7:0]};
    dict_re    = 1'b0;
    dict_raddr = code;
    stk_we     = 1'b0;
    stk_wdata  = cur[7:0];
    stk_re     = 1'b0;
    stk_raddr  = DICT_BITS'(sp - SP_W'(1));
    case (state)
      lzwvwd_pkg::S_IDLE: begin
        if (cmd_acc) begin
          state_next = lzwvwd_pkg::S_OUT;
          case (cmd.item.opcode)
            lzwvwd_pkg::OP_FEED: begin
              if (stack_empty && !corrupt && !done && have_code) begin
                state_next = lzwvwd_pkg::S_CODE;
              end
            end
            lzwvwd_pkg::OP_PULL: begin
              if (!stack_empty) begin
                stk_re     = 1'b1;
                state_next = lzwvwd_pkg::S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      lzwvwd_pkg::S_CODE: begin
        if (corrupt_hit) begin
          state_next = lzwvwd_pkg::S_OUT;
        end else if (fresh) begin
          state_next = lzwvwd_pkg::S_LIT;
        end else if (code < next_index) begin
          if (code >= LIT_LIMIT) begin
            dict_re    = 1'b1;
            state_next = lzwvwd_pkg::S_WALK;
          end else begin
            state_next = lzwvwd_pkg::S_LIT;
          end
        end else begin
          // code not yet in the dictionary: previous string plus its own first byte
          stk_we     = 1'b1;
          stk_wdata  = first_char;
          dict_raddr = prev_code;
          if (prev_code >= LIT_LIMIT) begin
            dict_re    = 1'b1;
            state_next = lzwvwd_pkg::S_WALK;
          end else begin
            state_next = lzwvwd_pkg::S_LIT;
          end
        end
      end
      lzwvwd_pkg::S_WALK: begin
        // push this entry's byte and chase its prefix, one entry per cycle
        stk_we     = 1'b1;
        stk_wdata  = dict_rdata[7:0];
        dict_raddr = walk_next;
        if (walk_next >= LIT_LIMIT) begin
          dict_re = 1'b1;
        end else begin
          state_next = lzwvwd_pkg::S_LIT;
        end
      end
      lzwvwd_pkg::S_LIT: begin
        stk_we     = 1'b1;
        state_next = lzwvwd_pkg::S_UPD;
      end
      lzwvwd_pkg::S_UPD: begin
        if (!was_fresh && next_index != RST_IDX) begin
          dict_we = 1'b1;
        end
        state_next = lzwvwd_pkg::S_OUT;
      end
      lzwvwd_pkg::S_POP: begin
        state_next = lzwvwd_pkg::S_OUT;
      end
      lzwvwd_pkg::S_OUT: begin
        if (slot_free) begin
          state_next = lzwvwd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lzwvwd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzwvwd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Length register: the user must write it only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      out_len <= LEN_W'(1);
    end else if (length_we) begin
      out_len <= length_data;
    end
  end

  // Decoder state and stack pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      held          <= '0;
      prev_code     <= '0;
      next_index    <= LIT_LIMIT;
      code_width    <= CW_START;
      width_limit   <= LIM_START;
      first_char    <= '0;
      fresh         <= 1'b1;
      bytes_written <= '0;
      corrupt       <= 1'b0;
      sp            <= '0;
      base          <= '0;
    end else begin
      if (stk_we) begin
        sp <= sp + SP_W'(1);
      end
      case (state)
        lzwvwd_pkg::S_IDLE: begin
          if (cmd_acc) begin
            case (cmd.item.opcode)
              lzwvwd_pkg::OP_FEED: begin
                if (stack_empty && !corrupt && !done) begin
                  if (have_code) begin
                    acc  <= acc_keep;
                    held <= shamt;
                    sp   <= '0;
                    base <= '0;
                  end else begin
                    acc  <= acc_ext;
                    held <= held_ext;
                  end
                end
              end
              lzwvwd_pkg::OP_PULL: begin
                if (!stack_empty) begin
                  sp <= sp - SP_W'(1);
                end
              end
              lzwvwd_pkg::OP_RESTART: begin
                acc           <= '0;
                held          <= '0;
                prev_code     <= '0;
                next_index    <= LIT_LIMIT;
                code_width    <= CW_START;
                width_limit   <= LIM_START;
                first_char    <= '0;
                fresh         <= 1'b1;
                bytes_written <= '0;
                corrupt       <= 1'b0;
                sp            <= '0;
                base          <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        lzwvwd_pkg::S_CODE: begin
          if (corrupt_hit) begin
            corrupt <= 1'b1;
          end
        end
        lzwvwd_pkg::S_UPD: begin
          if (!was_fresh) begin
            if (next_index == RST_IDX) begin
              // dictionary full: start over with literals at 9 bits
              next_index  <= LIT_LIMIT;
              code_width  <= CW_START;
              width_limit <= LIM_START;
              fresh       <= 1'b1;
            end else begin
              next_index <= next_index + DICT_BITS'(1);
              if (next_index + DICT_BITS'(1) == width_limit && code_width < CW_MAX) begin
                code_width  <= code_width + 5'd1;
                width_limit <= {width_limit[DICT_BITS-2:0], 1'b1};
              end
            end
          end else begin
            fresh <= 1'b0;
          end
          first_char <= cur[7:0];
          prev_code  <= code;
          // drop the tail beyond the expected length; the first bytes sit on top
          if (trunc) begin
            base <= sp - keep;
          end
          bytes_written <= bytes_written + LEN_W'(keep);
        end
        default: begin
        end
      endcase
    end
  end

  // Work registers of the transaction in flight
  always_ff @(posedge clk) begin
    case (state)
      lzwvwd_pkg::S_IDLE: begin
        if (cmd_acc) begin
          res_accepted <= 1'b0;
          res_valid    <= 1'b0;
          res_byte     <= '0;
          res_last     <= 1'b0;
          code         <= code_new;
          was_fresh    <= fresh;
          case (cmd.item.opcode)
            lzwvwd_pkg::OP_FEED: begin
              res_accepted <= stack_empty;
            end
            lzwvwd_pkg::OP_PULL: begin
              res_valid <= !stack_empty;
              res_last  <= !stack_empty && (sp - SP_W'(1) == base)
                           && (bytes_written == out_len);
            end
            default: begin
            end
          endcase
        end
      end
      lzwvwd_pkg::S_CODE: begin
        cur <= (fresh || code < next_index) ? code : prev_code;
      end
      lzwvwd_pkg::S_WALK: begin
        cur <= walk_next;
      end
      lzwvwd_pkg::S_POP: begin
        res_byte <= stk_rdata;
      end
      default: begin
      end
    endcase
  end

  // Result register: parts the decoder from the response channel
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (state == lzwvwd_pkg::S_OUT && slot_free) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lzwvwd_pkg::S_OUT && slot_free) begin
      out_item.accepted  <= res_accepted;
      out_item.out_valid <= res_valid;
      out_item.out_byte  <= res_byte;
      out_item.last_byte <= res_last;
      if (corrupt) begin
        out_item.status <= lzwvwd_pkg::STAT_CORRUPT;
      end else if (done && stack_empty) begin
        out_item.status <= lzwvwd_pkg::STAT_DONE;
      end else begin
        out_item.status <= lzwvwd_pkg::STAT_RUN;
      end
    end
  end

  assign rsp.valid = out_v;
  assign rsp.item  = out_item;

`ifndef ASSERT_OFF
  a_stack_order: assert property (@(posedge clk) disable iff (rst) base <= sp)
    else $error("stack base above top");
  a_dict_port: assert property (@(posedge clk) disable iff (rst) !(dict_we && dict_re))
    else $error("dictionary read and write in one cycle");
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    next_index >= LIT_LIMIT && next_index <= RST_IDX)
    else $error("next free index out of range");
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    code_width >= CW_START && code_width <= CW_MAX)
    else $error("code width out of range");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |=> state != lzwvwd_pkg::S_IDLE)
    else $error("transaction accepted without leaving idle");
`endif

endmodule
